/* rtl/bdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

   // Ring geometry.
   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Fixed field widths.
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 16;
   localparam int STATUS_W   = 2;
   localparam int OUT_CNT_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_FIND       = 3'd4,
      ACT_READ       = 3'd5,
      ACT_CLEAR      = 3'd6
   } bdq_action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } bdq_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SEARCH,
      ST_FINISH
   } bdq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic read_done;
      logic search;
      logic load_out;
   } bdq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_read;
      logic need_search;
      logic search_end;
   } bdq_stat_type;

   // Ring slot that lies off entries behind the front.
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                               input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(front) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Fit a count into the 7-bit result fields, dropping any upper bits.
   function automatic logic [OUT_CNT_W-1:0] fit7(input logic [CNT_W-1:0] v);
      logic [CNT_W+OUT_CNT_W-1:0] w;
      w = {{OUT_CNT_W{1'b0}}, v};
      return w[OUT_CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/bounded_deque_with_search.sv */
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// The request channel carries one word per action: push front, push back,
// pop front, pop back, find a value, read a 1-based position, or clear.
// Every request word produces exactly one response word on the rsp_ channel
// with a status code, the found position, the read value and the entry count
// left after the action. Both channels use valid and stall; a word moves on
// a rising edge where valid is high and stall is low.
// Pushes, pops, clears and rejected requests go through the execute and
// finish states; the finish state loads the output register and raises
// rsp_valid. A position read adds a read state for the registered RAM read.
// A find walks the queue from the front one entry per cycle in a search state.
// The block handles one request at a time; the next request is accepted in
// the cycle after the previous result has moved into the output register,
// even while that register is still held by a stalled receiver.
// Synchronous reset empties the queue and drops any pending response. The
// RAM contents are not cleared; only entries written by pushes are read.
// When the receiver stalls, the response word holds steady and a finished
// result waits in the datapath registers until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic        [bdq_pkg::ACTION_W-1:0]    req_action,
   input  wire logic signed [bdq_pkg::VALUE_W-1:0]     req_value,
   input  wire logic        [bdq_pkg::POSITION_W-1:0]  req_position,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic             [bdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic             [bdq_pkg::OUT_CNT_W-1:0]   rsp_found_position,
   output logic signed      [bdq_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic             [bdq_pkg::OUT_CNT_W-1:0]   rsp_entry_count
);
   import bdq_pkg::*;

   // Commands and status between the sequencer and the datapath.
   bdq_cmd_type  cmd;
   bdq_stat_type stat;

   // The controller owns the handshakes and steps through each action.
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the ring RAM, the front pointer, the count and the
   // response register.
   bdq_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_value     (rsp_read_value),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule

`default_nettype wire

/* rtl/bdq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire bdq_pkg::bdq_stat_type stat,
   output bdq_pkg::bdq_cmd_type      cmd
);
   import bdq_pkg::*;

   bdq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   // The output register can take a new word when it is empty or being read.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.need_read) begin
               state_in = ST_READ;
            end else if (stat.need_search) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_SEARCH: begin
            if (stat.search_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_READ: begin
            cmd.read_done = 1'b1;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_out = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/bdq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module bdq_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire bdq_pkg::bdq_cmd_type                   cmd,
   output bdq_pkg::bdq_stat_type                       stat,
   input  wire logic        [bdq_pkg::ACTION_W-1:0]    req_action,
   input  wire logic signed [bdq_pkg::VALUE_W-1:0]     req_value,
   input  wire logic        [bdq_pkg::POSITION_W-1:0]  req_position,
   output logic             [bdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic             [bdq_pkg::OUT_CNT_W-1:0]   rsp_found_position,
   output logic signed      [bdq_pkg::VALUE_W-1:0]     rsp_read_value,
   output logic             [bdq_pkg::OUT_CNT_W-1:0]   rsp_entry_count
);
   import bdq_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] mem_q;

   bdq_action_type          action_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic [POSITION_W-1:0]   position_ff;

   logic [IDX_W-1:0]        front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;

   bdq_status_type          res_status_ff, res_status_in;
   logic [OUT_CNT_W-1:0]    res_found_ff, res_found_in;
   logic [VALUE_W-1:0]      res_read_ff, res_read_in;

   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [OUT_CNT_W-1:0]    rsp_found_ff;
   logic [VALUE_W-1:0]      rsp_read_ff;
   logic [OUT_CNT_W-1:0]    rsp_count_ff;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [CNT_W-1:0]        rd_off;
   logic [IDX_W-1:0]        rd_addr;
   logic                    is_empty;
   logic                    is_full;
   logic                    pos_ok;
   logic [CNT_W-1:0]        scan_next;
   logic                    match;
   logic                    last;

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign pos_ok    = (position_ff != '0) && (position_ff <= POSITION_W'(count_ff));
   assign scan_next = scan_ff + CNT_W'(1);
   assign match     = (mem_q == value_ff);
   assign last      = (scan_next == count_ff);

   assign stat.need_read   = cmd.execute && (action_ff == ACT_READ) && !is_empty && pos_ok;
   assign stat.need_search = cmd.execute && (action_ff == ACT_FIND) && !is_empty;
   assign stat.search_end  = cmd.search && (match || last);

   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_read_in   = res_read_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_of(front_ff, count_ff);
      rd_off        = '0;

      if (cmd.execute) begin
         res_status_in = STAT_OK;
         res_found_in  = '0;
         res_read_in   = '0;
         scan_in       = '0;
         case (action_ff)
            ACT_PUSH_FRONT: begin
               if (is_full) begin
                  res_status_in = STAT_FULL;
               end else begin
                  front_in = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
                  wr_en    = 1'b1;
                  wr_addr  = front_in;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_PUSH_BACK: begin
               if (is_full) begin
                  res_status_in = STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_POP_FRONT: begin
               if (is_empty) begin
                  res_status_in = STAT_EMPTY;
               end else begin
                  front_in = slot_of(front_ff, CNT_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ACT_POP_BACK: begin
               if (is_empty) begin
                  res_status_in = STAT_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ACT_FIND: begin
               if (is_empty) begin
                  res_status_in = STAT_EMPTY;
               end else begin
                  res_status_in = STAT_NOT_FOUND;
               end
            end
            ACT_READ: begin
               rd_off = CNT_W'(position_ff - POSITION_W'(1));
               if (is_empty) begin
                  res_status_in = STAT_EMPTY;
               end else if (!pos_ok) begin
                  res_status_in = STAT_NOT_FOUND;
               end
            end
            ACT_CLEAR: begin
               front_in = '0;
               count_in = '0;
            end
            default: begin
               res_status_in = STAT_OK;
            end
         endcase
      end

      if (cmd.read_done) begin
         res_read_in = mem_q;
      end

      if (cmd.search) begin
         rd_off  = scan_next;
         scan_in = scan_next;
         if (match) begin
            res_status_in = STAT_OK;
            res_found_in  = fit7(scan_next);
         end
      end
   end

   assign rd_addr = slot_of(front_ff, rd_off);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      mem_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= bdq_action_type'(req_action);
         value_ff    <= req_value;
         position_ff <= req_position;
      end
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_read_ff   <= res_read_in;
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_count_ff  <= fit7(count_ff);
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the bounded deque with value search.
// A mirror of the deque sees every request word when it is accepted and
// queues the response word it predicts. Every response word that the block
// hands over is then checked, field by field, against the oldest prediction.

import bdq_pkg::*;

// One predicted response word.
typedef struct {
   bdq_status_type          status;
   logic [OUT_CNT_W-1:0]    found_position;
   logic signed [VALUE_W-1:0] read_value;
   logic [OUT_CNT_W-1:0]    entry_count;
} deque_result_type;

// Mirror of the deque contents, plus the list of response words still owed.
class deque_mirror;
   logic signed [VALUE_W-1:0] slots [DEPTH];
   int                        front;
   int                        held;
   deque_result_type          awaited_results [$];
   int                        errors;

   function new();
      front  = 0;
      held   = 0;
      errors = 0;
   endfunction

   function int pending();
      return awaited_results.size();
   endfunction

   function logic signed [VALUE_W-1:0] value_at(int off);
      return slots[(front + off) % DEPTH];
   endfunction

   task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // Apply one accepted request word and queue the response it must produce.
   function void note_request(input logic [ACTION_W-1:0] act,
                              input logic signed [VALUE_W-1:0] val,
                              input logic [POSITION_W-1:0] pos);
      deque_result_type r;
      int               k;
      r.status         = STAT_OK;
      r.found_position = '0;
      r.read_value     = '0;
      case (act)
         ACT_PUSH_FRONT: begin
            if (held >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               front        = (front + DEPTH - 1) % DEPTH;
               slots[front] = val;
               held++;
            end
         end
         ACT_PUSH_BACK: begin
            if (held >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               slots[(front + held) % DEPTH] = val;
               held++;
            end
         end
         ACT_POP_FRONT: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               front = (front + 1) % DEPTH;
               held--;
            end
         end
         ACT_POP_BACK: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               held--;
            end
         end
         ACT_FIND: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.status = STAT_NOT_FOUND;
               for (k = 0; k < held; k++) begin
                  if (value_at(k) == val) begin
                     r.found_position = OUT_CNT_W'(k + 1);
                     r.status         = STAT_OK;
                     break;
                  end
               end
            end
         end
         ACT_READ: begin
            if (held == 0) begin
               r.status = STAT_EMPTY;
            end else if (pos == 0 || int'(pos) > held) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               r.read_value = value_at(int'(pos) - 1);
            end
         end
         ACT_CLEAR: begin
            front = 0;
            held  = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = OUT_CNT_W'(held);
      awaited_results.push_back(r);
   endfunction

   task check_response(input logic [STATUS_W-1:0] st,
                       input logic [OUT_CNT_W-1:0] fp,
                       input logic signed [VALUE_W-1:0] rv,
                       input logic [OUT_CNT_W-1:0] ec);
      deque_result_type want;
      if (awaited_results.size() == 0) begin
         report("response word with no request outstanding");
      end else begin
         want = awaited_results.pop_front();
         if (st !== want.status)
            report($sformatf("status got %0d want %0d", st, want.status));
         if (fp !== want.found_position)
            report($sformatf("found_position got %0d want %0d", fp, want.found_position));
         if (rv !== want.read_value)
            report($sformatf("read_value got %0d want %0d", rv, want.read_value));
         if (ec !== want.entry_count)
            report($sformatf("entry_count got %0d want %0d", ec, want.entry_count));
      end
   endtask
endclass

module tb_top;

   localparam logic [ACTION_W-1:0]      ACT_UNUSED  = 3'd7;
   localparam logic signed [VALUE_W-1:0] VAL_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN    = 32'sh8000_0000;
   localparam int                        QUIET_LIMIT = 3000;
   localparam int                        PHASE_WORDS = 620;
   localparam int                        BLOCK_WORDS = 128;

   // Random traffic modes: fill toward full, drain toward empty, or mix.
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ACTION_W-1:0]           req_action = '0;
   logic signed [VALUE_W-1:0]     req_value = '0;
   logic [POSITION_W-1:0]         req_position = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [STATUS_W-1:0]           rsp_status;
   logic [OUT_CNT_W-1:0]          rsp_found_position;
   logic signed [VALUE_W-1:0]     rsp_read_value;
   logic [OUT_CNT_W-1:0]          rsp_entry_count;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   deque_mirror book;

   bounded_deque_with_search uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_value     (rsp_read_value),
      .rsp_entry_count    (rsp_entry_count)
   );

   always #6 clock = ~clock;

   // The receiver stalls at random, one decision per cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Every response word taken by the receiver is checked right away.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         book.check_response(rsp_status, rsp_found_position, rsp_read_value,
                             rsp_entry_count);
      end
   end

   // The run ends in failure if neither channel moves a word for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   // Offer one request word, after a random idle gap, and hold it until the
   // block takes it. Called and returns at a falling edge; valid stays high
   // on return so back-to-back words need no extra assignment.
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic signed [VALUE_W-1:0] val,
                            input logic [POSITION_W-1:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= pos;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      book.note_request(act, val, pos);
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (book.pending() != 0);
   endtask

   // Small values repeat often, which gives searches duplicate matches.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      int                        r;
      r = $urandom_range(7);
      if (r < 2) begin
         v = $urandom_range(6);
         v = v - 3;
      end else if (r == 2) begin
         v = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   task automatic send_random_word(input int mode);
      int                        r;
      int                        push_w;
      int                        pop_w;
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] val;
      logic [POSITION_W-1:0]     pos;
      push_w = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 15 : 35;
      pop_w  = (mode == MODE_FILL) ? 10 : (mode == MODE_DRAIN) ? 55 : 30;
      r   = $urandom_range(99);
      val = pick_value();
      pos = POSITION_W'($urandom);
      if (r < push_w) begin
         act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else if (r < push_w + pop_w) begin
         act = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
      end else if (r < 97) begin
         if ($urandom_range(1)) begin
            act = ACT_FIND;
            // Mostly search for something that is really held.
            if (book.held > 0 && $urandom_range(9) < 6)
               val = book.value_at($urandom_range(book.held - 1));
         end else begin
            act = ACT_READ;
            if (book.held > 0 && $urandom_range(9) < 8) begin
               pos = POSITION_W'($urandom_range(book.held, 1));
            end else begin
               case ($urandom_range(2))
                  0: pos = '0;
                  1: pos = POSITION_W'(book.held + 1);
                  default: begin
                  end
               endcase
            end
         end
      end else if (r < 99) begin
         // Clearing would undo a fill run, so it is left out there.
         act = (mode == MODE_FILL) ? ACT_PUSH_BACK : ACT_CLEAR;
      end else begin
         act = ACT_UNUSED;
      end
      send_word(act, val, pos);
   endtask

   task automatic run_random(input int count);
      int mode;
      int i;
      mode = MODE_MIX;
      for (i = 0; i < count; i++) begin
         if (i % BLOCK_WORDS == 0) mode = $urandom_range(MODE_MIX);
         send_random_word(mode);
      end
   endtask

   initial begin
      book = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 19;
      recv_idle_pct = 48;

      // Directed words: pops, find and read on an empty queue, the extreme values,
      // wrap of the front index below slot zero, first of duplicate matches,
      // out-of-range positions, the unused action code, and clear.
      send_word(ACT_POP_FRONT, '0, '0);
      send_word(ACT_POP_BACK, '0, '0);
      send_word(ACT_FIND, '0, '0);
      send_word(ACT_READ, '0, 16'd1);
      send_word(ACT_UNUSED, '0, '0);
      send_word(ACT_PUSH_BACK, VAL_MAX, '0);
      send_word(ACT_PUSH_FRONT, VAL_MIN, '0);
      send_word(ACT_PUSH_BACK, '0, '0);
      send_word(ACT_PUSH_FRONT, -32'sd1, '0);
      send_word(ACT_PUSH_BACK, -32'sd1, '0);
      send_word(ACT_FIND, -32'sd1, '0);
      send_word(ACT_FIND, VAL_MAX, '0);
      send_word(ACT_FIND, '0, '0);
      send_word(ACT_FIND, 32'sd12345, '0);
      send_word(ACT_READ, '0, 16'd0);
      send_word(ACT_READ, '0, 16'd5);
      send_word(ACT_READ, '0, 16'd6);
      send_word(ACT_READ, '0, 16'hFFFF);
      send_word(ACT_READ, '0, 16'd2);
      send_word(ACT_POP_FRONT, '0, '0);
      send_word(ACT_POP_BACK, '0, '0);
      send_word(ACT_UNUSED, -32'sd1, 16'hFFFF);
      send_word(ACT_CLEAR, '0, '0);
      send_word(ACT_READ, '0, 16'd1);

      // Let everything drain before the random traffic starts.
      wait_drained();
      run_random(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 48;
      recv_idle_pct = 19;
      run_random(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_WORDS);
      wait_drained();

      // A quiet tail catches any response word the block emits unasked.
      repeat (80) @(posedge clock);
      if (book.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
